[design/ssq_pkg.sv]
// ----------------------------------------------------------------------------
// ssq_pkg: shared types and constants of the severity priority queue
// Entry layout, per-cell command bundle, operation, severity and status codes.
// ----------------------------------------------------------------------------
package ssq_pkg;

   localparam int DEPTH_DEF = 16;   // default number of slots
   localparam int MAX_LIST  = 16;   // most entries one list request streams
   localparam int POS_W     = 4;    // width of the reported position

   // operation codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_SERVE  = 2'd1;
   localparam logic [1:0] OP_LIST   = 2'd2;

   // severity classes
   localparam logic [1:0] SEV_CRITICAL = 2'd0;
   localparam logic [1:0] SEV_SERIOUS  = 2'd1;
   localparam logic [1:0] SEV_REGULAR  = 2'd2;

   // result status
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]  sev;
      logic [15:0] tag;
      logic [6:0]  age;
      logic        gender;
   } ssq_entry_type;

   // broadcast to every cell
   typedef struct packed {
      logic          insert;       // insert takes effect this cycle
      logic          ins_crit;     // inserted record is critical
      logic          ins_serious;  // inserted record is serious
      logic          new_regular;  // inserted record is regular
      ssq_entry_type entry;        // the inserted record
      logic          load;         // copy slots into the read chain
      logic          shift;        // move the read chain one cell toward slot 0
   } ssq_cmd_type;

endpackage

[design/stable_severity_priority_queue.sv]
// ----------------------------------------------------------------------------
// stable_severity_priority_queue: ordered record list with severity insert
// Row of slot cells updated in parallel on insert; serve and list via a read chain.
// ----------------------------------------------------------------------------
// Usage:
//  - A command transfer happens at a clock edge with start high and busy low.
//    req_operation: insert, serve next, or list all entries; code 3 is ignored.
//  - Each result is shown for one cycle with rsp_strobe high; the receiver
//    cannot stall, so results are never held back. rsp_last marks the final
//    result of a command.
//  - Insert: result in the next cycle; busy stays low, so inserts
//    go at one per cycle. Every cell decides locally whether it keeps, takes
//    its left neighbor's entry or takes the new record.
//  - Serve: the slots are copied into a read chain that shifts toward slot 0
//    one cell per cycle; the result is registered from the chain head after
//    serve_index shifts, busy high meanwhile.
//  - List: one entry per cycle from slot 0 upward, min(count, 16) entries
//    in total, busy high meanwhile.
//  - Failed serve / empty list: a single status result in the next cycle.
//  - Reset empties the list and clears the serve index; slot contents are
//    not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module stable_severity_priority_queue
   import ssq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [1:0]  req_severity,
   input  logic [15:0] req_record_tag,
   input  logic [6:0]  req_age_years,
   input  logic        req_gender_bit,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_position,
   output logic [1:0]  rsp_out_severity,
   output logic [15:0] rsp_out_tag,
   output logic [6:0]  rsp_out_age,
   output logic        rsp_out_gender,
   output logic        rsp_last
);

   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int PX_W     = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int LIST_MAX = (DEPTH < MAX_LIST) ? DEPTH : MAX_LIST;

   typedef enum logic [1:0] {S_IDLE, S_SEEK, S_LIST} state_type;

   state_type      state_ff;
   logic [CNT_W-1:0] count_ff;   // entries held
   logic [CNT_W-1:0] serve_ff;   // next slot to serve
   logic [CNT_W-1:0] rem_ff;     // shifts left (seek) or entries left (list)
   logic [CNT_W-1:0] pos_ff;     // slot reported with the next result

   logic             strobe_ff, last_ff;
   logic [1:0]       status_ff;
   logic [POS_W-1:0] position_ff;
   ssq_entry_type    out_ff;

   // cell chain
   ssq_entry_type    slot_q [DEPTH];
   ssq_entry_type    rd_q   [DEPTH];
   logic [DEPTH-1:0] ge_vec, r_vec, ge_left_vec, r_left_vec, first_vec;
   ssq_cmd_type      cmd;

   logic             accept, full, serve_ok;
   logic [IDX_W-1:0] ins_idx;
   logic [PX_W-1:0]  ins_px, pos_px;
   logic [CNT_W-1:0] list_n;

   assign accept   = start & ~busy;
   assign full     = (count_ff >= CNT_W'(DEPTH));
   assign serve_ok = (serve_ff < count_ff);
   assign list_n   = (count_ff > CNT_W'(LIST_MAX)) ? CNT_W'(LIST_MAX) : count_ff;

   assign ge_left_vec = {ge_vec[DEPTH-2:0], 1'b0};
   assign r_left_vec  = {r_vec[DEPTH-2:0], 1'b0};
   assign first_vec   = ge_vec & ~ge_left_vec;

   always_comb begin
      cmd              = '0;
      cmd.insert       = accept && (req_operation == OP_INSERT) && !full;
      cmd.ins_crit     = (req_severity == SEV_CRITICAL);
      cmd.ins_serious  = (req_severity == SEV_SERIOUS);
      cmd.new_regular  = (req_severity == SEV_REGULAR);
      cmd.entry.sev    = req_severity;
      cmd.entry.tag    = req_record_tag;
      cmd.entry.age    = req_age_years;
      cmd.entry.gender = req_gender_bit;
      cmd.load         = accept && (((req_operation == OP_SERVE) && serve_ok) ||
                                    ((req_operation == OP_LIST) && (count_ff != '0)));
      cmd.shift        = ((state_ff == S_SEEK) && (rem_ff != '0)) || (state_ff == S_LIST);
   end

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic          occ;
         ssq_entry_type left_entry, right_rd;
         assign occ = (CNT_W'(gi) < count_ff);
         if (gi == 0) begin : g_head
            assign left_entry = '0;
         end else begin : g_body
            assign left_entry = slot_q[gi-1];
         end
         if (gi == DEPTH - 1) begin : g_tail
            assign right_rd = '0;
         end else begin : g_mid
            assign right_rd = rd_q[gi+1];
         end
         ssq_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .occupied   (occ),
            .left_entry (left_entry),
            .left_r     (r_left_vec[gi]),
            .left_ge    (ge_left_vec[gi]),
            .right_rd   (right_rd),
            .entry      (slot_q[gi]),
            .r_flag     (r_vec[gi]),
            .ge         (ge_vec[gi]),
            .rd         (rd_q[gi])
         );
      end
   endgenerate

   // insert position: index of the single first cell at or after it
   always_comb begin
      ins_idx = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (first_vec[i]) begin
            ins_idx = ins_idx | IDX_W'(i);
         end
      end
   end

   assign ins_px = PX_W'(ins_idx);
   assign pos_px = PX_W'(pos_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         serve_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  unique case (req_operation)
                     OP_INSERT: begin
                        strobe_ff <= 1'b1;
                        last_ff   <= 1'b1;
                        out_ff    <= '0;
                        if (full) begin
                           status_ff   <= ST_FULL;
                           position_ff <= '0;
                        end else begin
                           status_ff   <= ST_OK;
                           position_ff <= ins_px[POS_W-1:0];
                           count_ff    <= count_ff + CNT_W'(1);
                        end
                     end
                     OP_SERVE: begin
                        if (serve_ok) begin
                           strobe_ff <= 1'b0;
                           state_ff  <= S_SEEK;
                           rem_ff    <= serve_ff;
                           pos_ff    <= serve_ff;
                           serve_ff  <= serve_ff + CNT_W'(1);
                        end else begin
                           strobe_ff   <= 1'b1;
                           last_ff     <= 1'b1;
                           out_ff      <= '0;
                           status_ff   <= ST_EMPTY;
                           position_ff <= '0;
                        end
                     end
                     OP_LIST: begin
                        if (count_ff != '0) begin
                           strobe_ff <= 1'b0;
                           state_ff  <= S_LIST;
                           rem_ff    <= list_n;
                           pos_ff    <= '0;
                        end else begin
                           strobe_ff   <= 1'b1;
                           last_ff     <= 1'b1;
                           out_ff      <= '0;
                           status_ff   <= ST_EMPTY;
                           position_ff <= '0;
                        end
                     end
                     default: strobe_ff <= 1'b0;  // unused code: no result
                  endcase
               end else begin
                  strobe_ff <= 1'b0;
               end
            end
            S_SEEK: begin
               if (rem_ff == '0) begin
                  strobe_ff   <= 1'b1;
                  last_ff     <= 1'b1;
                  out_ff      <= rd_q[0];
                  status_ff   <= ST_OK;
                  position_ff <= pos_px[POS_W-1:0];
                  state_ff    <= S_IDLE;
               end else begin
                  strobe_ff <= 1'b0;
                  rem_ff    <= rem_ff - CNT_W'(1);
               end
            end
            S_LIST: begin
               strobe_ff   <= 1'b1;
               last_ff     <= (rem_ff == CNT_W'(1));
               out_ff      <= rd_q[0];
               status_ff   <= ST_OK;
               position_ff <= pos_px[POS_W-1:0];
               rem_ff      <= rem_ff - CNT_W'(1);
               pos_ff      <= pos_ff + CNT_W'(1);
               if (rem_ff == CNT_W'(1)) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               strobe_ff <= 1'b0;
               state_ff  <= S_IDLE;
            end
         endcase
      end
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_position     = position_ff;
   assign rsp_out_severity = out_ff.sev;
   assign rsp_out_tag      = out_ff.tag;
   assign rsp_out_age      = out_ff.age;
   assign rsp_out_gender   = out_ff.gender;
   assign rsp_last         = last_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond depth");

   a_single_first: assert property (@(posedge clock) disable iff (reset)
      $onehot0(first_vec))
      else $error("more than one insert point in the cell row");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow the list");

   a_serve_in_range: assert property (@(posedge clock) disable iff (reset)
      serve_ff <= count_ff)
      else $error("serve index past entry count");
`endif

endmodule

[design/ssq_cell.sv]
// ----------------------------------------------------------------------------
// ssq_cell: one slot of the queue
// Holds an entry, a "regular at or before here" flag and one read-chain stage.
// ----------------------------------------------------------------------------
module ssq_cell
   import ssq_pkg::*;
(
   input  logic          clock,
   input  ssq_cmd_type   cmd,
   input  logic          occupied,
   input  ssq_entry_type left_entry,
   input  logic          left_r,
   input  logic          left_ge,
   input  ssq_entry_type right_rd,
   output ssq_entry_type entry,
   output logic          r_flag,
   output logic          ge,
   output ssq_entry_type rd
);

   ssq_entry_type entry_ff, entry_in;
   ssq_entry_type rd_ff, rd_in;
   logic          r_ff, r_in;

   // slot index >= insert position; criticals form a prefix and r is monotone
   assign ge = ~occupied
             | (cmd.ins_crit & (entry_ff.sev != SEV_CRITICAL))
             | (cmd.ins_serious & r_ff);

   always_comb begin
      entry_in = entry_ff;
      r_in     = r_ff;
      if (cmd.insert && ge) begin
         entry_in = left_ge ? left_entry : cmd.entry;
         r_in     = left_r | cmd.new_regular;
      end
   end

   always_comb begin
      rd_in = rd_ff;
      if (cmd.load) begin
         rd_in = entry_ff;
      end else if (cmd.shift) begin
         rd_in = right_rd;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      r_ff     <= r_in;
      rd_ff    <= rd_in;
   end

   assign entry  = entry_ff;
   assign r_flag = r_ff;
   assign rd     = rd_ff;

endmodule
